// ===== src/bha_pkg.sv =====
package bha_pkg;

   localparam int HEAP_PAGES_DEF   = 4;
   localparam int BITMAP_BYTES_DEF = 455;

   // Fixed field widths of the request and response channels.
   localparam int LEN_W    = 12;
   localparam int OFF_W    = 12;
   localparam int PAGE_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADLEN   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BADRANGE = 2'd3;

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_SCAN    = 6'b000100,
      S_MARK_RD = 6'b001000,
      S_MARK_WR = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

endpackage

// ===== src/bitmap_heap_allocator.sv =====
// A bad-length or bad-range request goes straight from idle to the response state.
// An allocate scans one bitmap byte per cycle through the bitmap memory's read port,
// at most once over every page, then reads and writes back each bitmap byte it marks.
// A free reads and writes back each bitmap byte it touches.
// One transaction is in flight at a time; the next is taken once the result is registered.
// After reset a clearing pass zeroes every byte of the bitmap.
module bitmap_heap_allocator
   import bha_pkg::*;
#(
   parameter int HEAP_PAGES   = HEAP_PAGES_DEF,
   parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [LEN_W-1:0]    req_length,
   input  logic [PAGE_W-1:0]   req_free_page,
   input  logic [OFF_W-1:0]    req_free_offset,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_block_page,
   output logic [OFF_W-1:0]    rsp_block_offset
);

   localparam int DEPTH  = HEAP_PAGES * BITMAP_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BYTE_W = $clog2(BITMAP_BYTES);
   localparam int PG_W   = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
   localparam int POS_W  = $clog2(BITMAP_BYTES * 8 + 1);
   localparam int SUM_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
   localparam int BIDX_W = SUM_W - 3;
   localparam logic [SUM_W-1:0] DATA_BYTES = SUM_W'(BITMAP_BYTES * 8);

   logic [7:0] bitmap_mem [DEPTH];

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [LEN_W-1:0]    len_ff, len_in;

   // Scan issue side: address sent to the memory this cycle.
   logic                issue_on_ff, issue_on_in;
   logic [ADDR_W-1:0]   issue_addr_ff, issue_addr_in;
   logic [ADDR_W-1:0]   issue_base_ff, issue_base_in;
   logic [BYTE_W-1:0]   issue_byte_ff, issue_byte_in;
   logic [PG_W-1:0]     issue_page_ff, issue_page_in;

   // Scan check side: describes the byte whose data arrives this cycle.
   logic                chk_valid_ff, chk_valid_in;
   logic                chk_first_ff, chk_first_in;
   logic                chk_last_ff, chk_last_in;
   logic [BYTE_W-1:0]   chk_byte_ff, chk_byte_in;
   logic [PG_W-1:0]     chk_page_ff, chk_page_in;
   logic [ADDR_W-1:0]   chk_base_ff, chk_base_in;

   logic [SUM_W-1:0]    run_ff, run_in;
   logic [SUM_W-1:0]    start_ff, start_in;

   logic [SUM_W-1:0]    mark_first_ff, mark_first_in;
   logic [SUM_W-1:0]    mark_end_ff, mark_end_in;
   logic [BIDX_W-1:0]   mark_cur_ff, mark_cur_in;
   logic [ADDR_W-1:0]   mark_base_ff, mark_base_in;
   logic                mark_set_ff, mark_set_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [OFF_W-1:0]    res_offset_ff, res_offset_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [OFF_W-1:0]    rsp_offset_ff, rsp_offset_in;

   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [7:0]          mem_wdata;

   logic                bad_len, bad_range;
   logic [ADDR_W-1:0]   free_base;
   logic [SUM_W-1:0]    run_prev, run_new, start_new;
   logic                byte_zero, found;
   logic [BIDX_W-1:0]   mark_first_byte, mark_last_byte;
   logic [ADDR_W-1:0]   mark_addr;
   logic [7:0]          lo_mask, hi_mask, bit_mask;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_page   = rsp_page_ff;
   assign rsp_block_offset = rsp_offset_ff;

   assign bad_len   = (req_length == '0) || (SUM_W'(req_length) > DATA_BYTES);
   assign bad_range = (32'(req_free_page) >= 32'(HEAP_PAGES))
                      || ((SUM_W'(req_free_offset) + SUM_W'(req_length)) > DATA_BYTES);
   assign free_base = ADDR_W'(req_free_page) * ADDR_W'(BITMAP_BYTES);

   // A run restarts at each page; it only grows over wholly free bitmap bytes.
   assign byte_zero = (rd_data_ff == 8'h00);
   assign run_prev  = chk_first_ff ? '0 : run_ff;
   assign run_new   = byte_zero ? (run_prev + SUM_W'(8)) : '0;
   assign start_new = (run_prev == '0) ? (SUM_W'(chk_byte_ff) << 3) : start_ff;
   assign found     = chk_valid_ff && byte_zero && (run_new >= SUM_W'(len_ff));

   assign mark_first_byte = BIDX_W'(mark_first_ff >> 3);
   assign mark_last_byte  = BIDX_W'((mark_end_ff - SUM_W'(1)) >> 3);
   assign mark_addr       = mark_base_ff + ADDR_W'(mark_cur_ff);

   always_comb begin
      lo_mask = 8'hFF;
      hi_mask = 8'hFF;
      if (mark_cur_ff == mark_first_byte) begin
         lo_mask = 8'hFF << mark_first_ff[2:0];
      end
      if ((mark_cur_ff == mark_last_byte) && (mark_end_ff[2:0] != 3'd0)) begin
         hi_mask = ~(8'hFF << mark_end_ff[2:0]);
      end
      bit_mask = lo_mask & hi_mask;
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      len_in         = len_ff;
      issue_on_in    = issue_on_ff;
      issue_addr_in  = issue_addr_ff;
      issue_base_in  = issue_base_ff;
      issue_byte_in  = issue_byte_ff;
      issue_page_in  = issue_page_ff;
      chk_valid_in   = 1'b0;
      chk_first_in   = chk_first_ff;
      chk_last_in    = chk_last_ff;
      chk_byte_in    = chk_byte_ff;
      chk_page_in    = chk_page_ff;
      chk_base_in    = chk_base_ff;
      run_in         = run_ff;
      start_in       = start_ff;
      mark_first_in  = mark_first_ff;
      mark_end_in    = mark_end_ff;
      mark_cur_in    = mark_cur_ff;
      mark_base_in   = mark_base_ff;
      mark_set_in    = mark_set_ff;
      res_status_in  = res_status_ff;
      res_page_in    = res_page_ff;
      res_offset_in  = res_offset_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_offset_in  = rsp_offset_ff;
      mem_we         = 1'b0;
      mem_waddr      = clr_addr_ff;
      mem_wdata      = 8'h00;
      mem_raddr      = issue_addr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               len_in        = req_length;
               res_page_in   = '0;
               res_offset_in = '0;
               if (bad_len) begin
                  res_status_in = STAT_BADLEN;
                  state_in      = S_RESP;
               end else if (req_action == ACT_ALLOC) begin
                  issue_on_in   = 1'b1;
                  issue_addr_in = '0;
                  issue_base_in = '0;
                  issue_byte_in = '0;
                  issue_page_in = '0;
                  run_in        = '0;
                  res_status_in = STAT_NOSPACE;
                  state_in      = S_SCAN;
               end else if (bad_range) begin
                  res_status_in = STAT_BADRANGE;
                  state_in      = S_RESP;
               end else begin
                  mark_first_in = SUM_W'(req_free_offset);
                  mark_end_in   = SUM_W'(req_free_offset) + SUM_W'(req_length);
                  mark_cur_in   = BIDX_W'(req_free_offset >> 3);
                  mark_base_in  = free_base;
                  mark_set_in   = 1'b0;
                  res_status_in = STAT_OK;
                  state_in      = S_MARK_RD;
               end
            end
         end
         S_SCAN: begin
            mem_raddr = issue_addr_ff;
            if (issue_on_ff) begin
               chk_valid_in  = 1'b1;
               chk_first_in  = (issue_byte_ff == '0);
               chk_byte_in   = issue_byte_ff;
               chk_page_in   = issue_page_ff;
               chk_base_in   = issue_base_ff;
               chk_last_in   = (issue_byte_ff == BYTE_W'(BITMAP_BYTES - 1))
                               && (issue_page_ff == PG_W'(HEAP_PAGES - 1));
               issue_addr_in = issue_addr_ff + ADDR_W'(1);
               if (issue_byte_ff == BYTE_W'(BITMAP_BYTES - 1)) begin
                  issue_byte_in = '0;
                  issue_base_in = issue_base_ff + ADDR_W'(BITMAP_BYTES);
                  if (issue_page_ff == PG_W'(HEAP_PAGES - 1)) begin
                     issue_on_in = 1'b0;
                  end else begin
                     issue_page_in = issue_page_ff + PG_W'(1);
                  end
               end else begin
                  issue_byte_in = issue_byte_ff + BYTE_W'(1);
               end
            end
            if (chk_valid_ff) begin
               run_in   = run_new;
               start_in = start_new;
               if (found) begin
                  issue_on_in   = 1'b0;
                  mark_first_in = start_new;
                  mark_end_in   = start_new + SUM_W'(len_ff);
                  mark_cur_in   = BIDX_W'(start_new >> 3);
                  mark_base_in  = chk_base_ff;
                  mark_set_in   = 1'b1;
                  res_status_in = STAT_OK;
                  res_page_in   = PAGE_W'(chk_page_ff);
                  res_offset_in = OFF_W'(start_new);
                  state_in      = S_MARK_RD;
               end else if (chk_last_ff) begin
                  state_in = S_RESP;
               end
            end
         end
         S_MARK_RD: begin
            mem_raddr = mark_addr;
            state_in  = S_MARK_WR;
         end
         S_MARK_WR: begin
            mem_we    = 1'b1;
            mem_waddr = mark_addr;
            mem_wdata = mark_set_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
            if (mark_cur_ff == mark_last_byte) begin
               state_in = S_RESP;
            end else begin
               mark_cur_in = mark_cur_ff + BIDX_W'(1);
               state_in    = S_MARK_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_page_in   = res_page_ff;
               rsp_offset_in = res_offset_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bitmap_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         issue_on_ff  <= 1'b0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_on_ff  <= issue_on_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      issue_addr_ff <= issue_addr_in;
      issue_base_ff <= issue_base_in;
      issue_byte_ff <= issue_byte_in;
      issue_page_ff <= issue_page_in;
      chk_first_ff  <= chk_first_in;
      chk_last_ff   <= chk_last_in;
      chk_byte_ff   <= chk_byte_in;
      chk_page_ff   <= chk_page_in;
      chk_base_ff   <= chk_base_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      mark_first_ff <= mark_first_in;
      mark_end_ff   <= mark_end_in;
      mark_cur_ff   <= mark_cur_in;
      mark_base_ff  <= mark_base_in;
      mark_set_ff   <= mark_set_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start work");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |->
         ((rsp_page_ff == '0) && (rsp_offset_ff == '0)))
      else $error("error response carries a nonzero block location");

   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_offset_ff[2:0] == 3'd0))
      else $error("block offset is not aligned to a bitmap byte");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK_WR) |-> (mark_cur_ff <= mark_last_byte))
      else $error("bitmap update ran past the end of its range");

endmodule
